// ===== hw/rtl/bba_pkg.sv =====
// Shared types and constants for the buddy block allocator.
// No dependencies.
package bba_pkg;

  localparam int ListDepthDefault = 64;
  localparam int PoolOrderDefault = 10;
  localparam logic [7:0] FirstOwner = 8'd65;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_MEM   = 2'd1,
    ST_NO_OWNER = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

endpackage

// ===== hw/rtl/buddy_block_allocator_unit.sv =====
// Buddy block allocator top level: block list memory, sequencer, result register.
// Depends on bba_pkg.
//
// Sequence: a request walks the list entry by entry, then for each split shifts
// the tail up by one entry. A release walks once to free its owner's blocks, then
// runs merge passes, each a walk plus a tail shift. The result fields are registered
// as the sequencer finishes, and out_valid is raised from the done state.
// Throughput: one transaction is worked at a time; in_stall is high from
// acceptance until the result leaves the output register.
// Reset: the list holds one free block of the whole pool; next owner is 65.
// The list is a single-port memory paced by one shared index counter.
module buddy_block_allocator_unit #(
  parameter int LIST_DEPTH = bba_pkg::ListDepthDefault,
  parameter int POOL_ORDER = bba_pkg::PoolOrderDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] request_size,
  input  logic [7:0]  release_owner,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [3:0]  granted_order,
  output logic [9:0]  granted_offset,
  output logic [7:0]  owner_id
);

  localparam int IW = $clog2(LIST_DEPTH);
  localparam int CW = $clog2(LIST_DEPTH + 1);
  localparam int OFFW = POOL_ORDER + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_RQ_RD, S_RQ_CHK, S_SH_RD, S_SH_WR, S_SPLIT, S_GRANT,
    S_RL_RD, S_RL_CHK, S_MG_RD, S_MG_CHK, S_RM_RD, S_RM_WR, S_DONE
  } state_t;

  // entry word: order, free, owner
  logic [4:0]  mem_ord [LIST_DEPTH];
  logic        mem_free [LIST_DEPTH];
  logic [7:0]  mem_own [LIST_DEPTH];

  state_t        state;
  logic [CW-1:0] idx;
  logic [IW-1:0] sel;
  logic [4:0]    sel_ord;
  logic [CW-1:0] count;
  logic [CW-1:0] splits;
  logic [7:0]    next_owner;
  logic [4:0]    target;
  logic [OFFW-1:0] off;
  logic [OFFW-1:0] sel_off;
  logic          found;
  logic [7:0]    rel_id;
  logic [4:0]    rd_ord;
  logic          rd_free;
  logic [7:0]    rd_own;
  logic [4:0]    prev_ord;
  logic          prev_free;
  logic          have_prev;
  logic [OFFW-1:0] prev_off;
  logic [4:0]    tgt_calc;

  // round size up to a power of two
  always_comb begin
    tgt_calc = 5'd0;
    for (int b = 0; b < 17; b++) begin
      if (request_size > (17'd1 << b)) tgt_calc = 5'(b + 1);
    end
  end

  logic rd_en;
  logic [IW-1:0] rd_addr;
  logic wr_en;
  logic [IW-1:0] wr_addr;
  logic [4:0] wr_ord;
  logic wr_free;
  logic [7:0] wr_own;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_ord  <= mem_ord[rd_addr];
      rd_free <= mem_free[rd_addr];
      rd_own  <= mem_own[rd_addr];
    end
    if (rst) begin
      // load the reset image of entry zero: the whole pool, free
      mem_ord[0]  <= 5'(POOL_ORDER);
      mem_free[0] <= 1'b1;
    end else if (wr_en) begin
      mem_ord[wr_addr]  <= wr_ord;
      mem_free[wr_addr] <= wr_free;
      mem_own[wr_addr]  <= wr_own;
    end
  end

  // address and write control
  always_comb begin
    rd_en = 1'b0;
    rd_addr = IW'(idx);
    wr_en = 1'b0;
    wr_addr = IW'(idx);
    wr_ord = rd_ord;
    wr_free = rd_free;
    wr_own = rd_own;
    unique case (state)
      S_RQ_RD, S_RL_RD, S_MG_RD: rd_en = 1'b1;
      S_SH_RD: begin
        rd_en = 1'b1;
        rd_addr = IW'(idx - 1'b1);
      end
      S_SH_WR: wr_en = 1'b1;
      S_RM_RD: begin
        rd_en = 1'b1;
        rd_addr = IW'(idx + 1'b1);
      end
      S_RM_WR: wr_en = 1'b1;
      S_SPLIT: begin
        // the low half stays at sel; its final order is written at grant
        wr_en = 1'b1;
        wr_addr = sel + 1'b1;
        wr_ord = sel_ord - 5'd1;
        wr_free = 1'b1;
        wr_own = 8'd0;
      end
      S_GRANT: begin
        wr_en = 1'b1;
        wr_addr = sel;
        wr_ord = target;
        wr_free = 1'b0;
        wr_own = next_owner;
      end
      S_RL_CHK: begin
        wr_en = !rd_free && rd_own == rel_id;
        wr_addr = IW'(idx);
        wr_free = 1'b1;
        wr_own = 8'd0;
      end
      S_MG_CHK: begin
        wr_en = have_prev && rd_free && prev_free && rd_ord == prev_ord &&
                prev_ord < 5'(POOL_ORDER) &&
                (prev_off & ((OFFW'(1) << (prev_ord + 5'd1)) - 1'b1)) == '0;
        wr_addr = IW'(idx - 1'b1);
        wr_ord = prev_ord + 5'd1;
        wr_free = 1'b1;
        wr_own = 8'd0;
      end
      default: ;
    endcase
  end

  assign in_stall = (state != S_IDLE);

  logic mg_hit;
  assign mg_hit = wr_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= CW'(1);
      next_owner <= bba_pkg::FirstOwner;
      out_valid <= 1'b0;
      idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rel_id <= release_owner;
            target <= tgt_calc;
            idx <= '0;
            off <= '0;
            found <= 1'b0;
            have_prev <= 1'b0;
            state <= action ? S_RL_RD : S_RQ_RD;
          end
        end
        S_RQ_RD: begin
          if (target > 5'(POOL_ORDER) || idx >= count) begin
            status <= bba_pkg::ST_NO_MEM;
            granted_order <= '0;
            granted_offset <= '0;
            owner_id <= '0;
            state <= S_DONE;
          end else state <= S_RQ_CHK;
        end
        S_RQ_CHK: begin
          if (rd_free && rd_ord >= target) begin
            sel <= IW'(idx);
            sel_ord <= rd_ord;
            sel_off <= off;
            if (count + CW'(rd_ord - target) > CW'(LIST_DEPTH) ||
                (count + CW'(rd_ord - target)) < count) begin
              status <= bba_pkg::ST_FULL;
              granted_order <= '0;
              granted_offset <= '0;
              owner_id <= '0;
              state <= S_DONE;
            end else begin
              splits <= CW'(rd_ord - target);
              idx <= count;
              state <= (rd_ord == target) ? S_GRANT : S_SH_RD;
            end
          end else begin
            off <= off + (OFFW'(1) << rd_ord);
            idx <= idx + 1'b1;
            state <= S_RQ_RD;
          end
        end
        S_SH_RD: begin
          // move entries above sel up by one, top first
          if (idx == CW'(sel) + 1'b1) state <= S_SPLIT;
          else state <= S_SH_WR;
        end
        S_SH_WR: begin
          idx <= idx - 1'b1;
          state <= S_SH_RD;
        end
        S_SPLIT: begin
          sel_ord <= sel_ord - 5'd1;
          count <= count + 1'b1;
          splits <= splits - 1'b1;
          idx <= count + 1'b1;
          state <= (splits == CW'(1)) ? S_GRANT : S_SH_RD;
        end
        S_GRANT: begin
          status <= bba_pkg::ST_OK;
          granted_order <= target[3:0];
          granted_offset <= 10'(sel_off);
          owner_id <= next_owner;
          next_owner <= next_owner + 8'd1;
          state <= S_DONE;
        end
        S_RL_RD: begin
          if (idx >= count) begin
            if (found) begin
              idx <= '0;
              off <= '0;
              have_prev <= 1'b0;
              state <= S_MG_RD;
            end else begin
              status <= bba_pkg::ST_NO_OWNER;
              granted_order <= '0;
              granted_offset <= '0;
              owner_id <= '0;
              state <= S_DONE;
            end
          end else state <= S_RL_CHK;
        end
        S_RL_CHK: begin
          if (mg_hit) found <= 1'b1;
          idx <= idx + 1'b1;
          state <= S_RL_RD;
        end
        S_MG_RD: begin
          if (idx >= count) begin
            status <= bba_pkg::ST_OK;
            granted_order <= '0;
            granted_offset <= '0;
            owner_id <= rel_id;
            state <= S_DONE;
          end else state <= S_MG_CHK;
        end
        S_MG_CHK: begin
          if (mg_hit) begin
            // drop entry idx by pulling the tail down
            state <= S_RM_RD;
          end else begin
            prev_ord <= rd_ord;
            prev_free <= rd_free;
            prev_off <= off;
            have_prev <= 1'b1;
            off <= off + (OFFW'(1) << rd_ord);
            idx <= idx + 1'b1;
            state <= S_MG_RD;
          end
        end
        S_RM_RD: begin
          if (idx + 1'b1 >= count) begin
            count <= count - 1'b1;
            idx <= '0;
            off <= '0;
            have_prev <= 1'b0;
            state <= S_MG_RD;
          end else state <= S_RM_WR;
        end
        S_RM_WR: begin
          idx <= idx + 1'b1;
          state <= S_RM_RD;
        end
        S_DONE: begin
          if (out_valid && !out_stall) begin
            out_valid <= 1'b0;
            state <= S_IDLE;
          end else begin
            out_valid <= 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_buddy_block_allocator_unit.sv =====
// Self-checking testbench for buddy_block_allocator_unit: a built-in list allocator
// predicts every result, which the monitor compares against the block's outputs.
// Depends on bba_pkg and the RTL top level.
`timescale 1ns / 1ps

module tb_buddy_block_allocator_unit;

  localparam int Depth = bba_pkg::ListDepthDefault;
  localparam int Pool  = bba_pkg::PoolOrderDefault;

  typedef struct packed {
    logic        action;
    logic [15:0] size;
    logic [7:0]  owner;
  } req_t;

  typedef struct packed {
    bba_pkg::status_t st;
    logic [3:0]  ord;
    logic [9:0]  off;
    logic [7:0]  own;
  } grant_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic action = 1'b0;
  logic [15:0] request_size = '0;
  logic [7:0] release_owner = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] status;
  logic [3:0] granted_order;
  logic [9:0] granted_offset;
  logic [7:0] owner_id;

  buddy_block_allocator_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .request_size(request_size), .release_owner(release_owner),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .granted_order(granted_order),
    .granted_offset(granted_offset), .owner_id(owner_id)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block list
  logic [4:0] sh_order [Depth+1];
  logic       sh_free  [Depth+1];
  logic [7:0] sh_owner [Depth+1];
  int         sh_count;
  logic [7:0] sh_next;

  req_t   pending_reqs[$];
  grant_t awaited_grants[$];
  logic [7:0] live_ids[$];
  int  errors = 0;
  bit  quiet = 1'b0;      // no idling in the last part
  bit  stim_done = 1'b0;
  int  hold_off = 0;      // long receiver hold-off, in cycles
  int  gap_in = 0, gap_out = 0;

  function automatic void alloc_reset();
    sh_order[0] = Pool[4:0];
    sh_free[0]  = 1'b1;
    sh_owner[0] = '0;
    sh_count = 1;
    sh_next  = bba_pkg::FirstOwner;
  endfunction

  function automatic bit merge_pass();
    int i, j, off;
    off = 0;
    for (i = 0; i + 1 < sh_count; i++) begin
      if (sh_free[i] && sh_free[i+1] && sh_order[i+1] == sh_order[i] &&
          sh_order[i] < Pool && (off % (1 << (sh_order[i] + 1))) == 0) begin
        sh_order[i] = sh_order[i] + 5'd1;
        for (j = i + 1; j + 1 < sh_count; j++) begin
          sh_order[j] = sh_order[j+1];
          sh_free[j]  = sh_free[j+1];
          sh_owner[j] = sh_owner[j+1];
        end
        sh_count--;
        return 1'b1;
      end
      off += 1 << sh_order[i];
    end
    return 1'b0;
  endfunction

  function automatic grant_t alloc_step(req_t r);
    grant_t g;
    int t, i, j, s, k, off;
    bit found;
    g = '{bba_pkg::ST_NO_MEM, 4'd0, 10'd0, 8'd0};
    if (!r.action) begin
      t = 0;
      while ((1 << t) < r.size && t < 17) t++;
      if (t > Pool) return g;
      off = 0;
      for (i = 0; i < sh_count; i++) begin
        if (sh_free[i] && sh_order[i] >= t) begin
          k = sh_order[i] - t;
          if (sh_count + k > Depth) begin
            g.st = bba_pkg::ST_FULL;
            return g;
          end
          for (s = 0; s < k; s++) begin
            for (j = sh_count; j > i + 1; j--) begin
              sh_order[j] = sh_order[j-1];
              sh_free[j]  = sh_free[j-1];
              sh_owner[j] = sh_owner[j-1];
            end
            sh_order[i]   = sh_order[i] - 5'd1;
            sh_order[i+1] = sh_order[i];
            sh_free[i+1]  = 1'b1;
            sh_owner[i+1] = '0;
            sh_count++;
          end
          sh_free[i]  = 1'b0;
          sh_owner[i] = sh_next;
          g = '{bba_pkg::ST_OK, t[3:0], off[9:0], sh_next};
          live_ids.push_back(sh_next);
          sh_next = sh_next + 8'd1;
          return g;
        end
        off += 1 << sh_order[i];
      end
      return g;
    end
    found = 1'b0;
    for (i = 0; i < sh_count; i++)
      if (!sh_free[i] && sh_owner[i] == r.owner) begin
        sh_free[i] = 1'b1;
        sh_owner[i] = '0;
        found = 1'b1;
      end
    if (!found) begin
      g.st = bba_pkg::ST_NO_OWNER;
      return g;
    end
    while (merge_pass()) ;
    g = '{bba_pkg::ST_OK, 4'd0, 10'd0, r.owner};
    return g;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $time);
    errors++;
  endtask

  // Driver: offer the head of the queue, predict on acceptance
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        awaited_grants.push_back(alloc_step(pending_reqs.pop_front()));
      end
      if (in_valid && in_stall) begin
        // hold the stalled transaction
      end else if (gap_in > 0) begin
        gap_in <= gap_in - 1;
        in_valid <= 1'b0;
      end else if (pending_reqs.size() > 0 &&
                   !(!quiet && $urandom_range(0, 9) == 0)) begin
        req_t nx;
        nx = pending_reqs[0];
        in_valid <= 1'b1;
        action <= nx.action;
        request_size <= nx.size;
        release_owner <= nx.owner;
      end else begin
        in_valid <= 1'b0;
        if (!quiet && $urandom_range(0, 9) == 0) gap_in <= $urandom_range(1, 5);
      end
    end
  end

  // Count down the long receiver hold-off
  always @(posedge clk) begin
    if (!rst && hold_off > 0) hold_off <= hold_off - 1;
  end

  // Monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (awaited_grants.size() == 0) begin
          report_mismatch("unexpected result", status, -1);
        end else begin
          grant_t w;
          w = awaited_grants.pop_front();
          if (status != w.st) report_mismatch("status", status, w.st);
          if (granted_order != w.ord) report_mismatch("order", granted_order, w.ord);
          if (granted_offset != w.off) report_mismatch("offset", granted_offset, w.off);
          if (owner_id != w.own) report_mismatch("owner", owner_id, w.own);
        end
      end
      if (hold_off > 0) begin
        out_stall <= 1'b1;
      end else if (gap_out > 0) begin
        gap_out <= gap_out - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (!quiet && $urandom_range(0, 7) == 0) gap_out <= $urandom_range(1, 5);
      end
    end
  end

  function automatic req_t mk_req(logic act, logic [15:0] sz, logic [7:0] id);
    req_t r;
    r.action = act;
    r.size = sz;
    r.owner = id;
    return r;
  endfunction

  // Pick a small size most of the time; now and then the whole range
  function automatic logic [15:0] pick_size();
    case ($urandom_range(0, 9))
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 1024));
      default: return 16'($urandom_range(0, 16));
    endcase
  endfunction

  function automatic logic [7:0] pick_release();
    int k;
    if (live_ids.size() > 0 && $urandom_range(0, 4) != 0) begin
      k = $urandom_range(0, live_ids.size() - 1);
      return live_ids[k];
    end
    return 8'($urandom);
  endfunction

  initial begin
    int n, k;
    alloc_reset();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // Directed: zero size, exact pool, too large, unknown owner
    pending_reqs.push_back(mk_req(1'b0, 16'd0, 8'd0));
    pending_reqs.push_back(mk_req(1'b1, 16'hFFFF, 8'd65));
    pending_reqs.push_back(mk_req(1'b0, 16'd1024, 8'hFF));
    pending_reqs.push_back(mk_req(1'b0, 16'd1025, 8'd0));
    pending_reqs.push_back(mk_req(1'b0, 16'hFFFF, 8'd0));
    pending_reqs.push_back(mk_req(1'b1, 16'd0, 8'd0));
    pending_reqs.push_back(mk_req(1'b1, 16'd0, 8'hFF));
    for (n = 0; n < 12; n++) pending_reqs.push_back(mk_req(1'b0, 16'd1, 8'd0));
    pending_reqs.push_back(mk_req(1'b0, 16'd3, 8'hAA));
    pending_reqs.push_back(mk_req(1'b1, 16'd0, 8'd67));
    pending_reqs.push_back(mk_req(1'b1, 16'd0, 8'd66));
    pending_reqs.push_back(mk_req(1'b0, 16'd512, 8'd0));
    // Receiver holds off long while the sender keeps offering
    hold_off = 400;
    wait (pending_reqs.size() == 0 && awaited_grants.size() == 0);
    repeat (20) @(posedge clk);
    // Random: mostly requests/releases on live ids, drains now and then
    for (k = 0; k < 730; k++) begin
      // the predictor fills live_ids only on acceptance, so feed in small batches
      if (k % 10 == 0)
        wait (pending_reqs.size() == 0);
      if (k == 620) quiet = 1'b1;
      if ($urandom_range(0, 1) == 0)
        pending_reqs.push_back(mk_req(1'b0, pick_size(), 8'($urandom)));
      else
        pending_reqs.push_back(mk_req(1'b1, 16'($urandom), pick_release()));
      if (k == 300) begin
        // sender pauses until all results are in
        wait (pending_reqs.size() == 0 && awaited_grants.size() == 0);
        repeat (10) @(posedge clk);
      end
    end
    wait (pending_reqs.size() == 0 && awaited_grants.size() == 0);
    repeat (500) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #200000000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/bba_pkg.sv
hw/rtl/buddy_block_allocator_unit.sv
tb/sv/tb_buddy_block_allocator_unit.sv
